// ===== rtl/tcp_reassembly_range_tracker_unit_assert.svh =====
// Assertion macros shared by the range tracker modules.
`ifndef TCP_REASSEMBLY_RANGE_TRACKER_UNIT_ASSERT_SVH
`define TCP_REASSEMBLY_RANGE_TRACKER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define TRT_ASSERT_IMPL(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define TRT_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/trt_pkg.sv =====
// ----------------------------------------------------------------------------
// trt_pkg
// Types and constants of the TCP reassembly range tracker.
// ----------------------------------------------------------------------------
package trt_pkg;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned LEN_W = 21;
  localparam int unsigned TOT_W = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [SEQ_W-1:0] SEQ_HALF = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_NO_ROOM = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_SIZE      = 1'b0,
    REG_INITIAL_SEQUENCE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [SEQ_W-1:0] segment_sequence;
    logic [LEN_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] bytes_done;
    logic [LEN_W-1:0] contiguous_length;
    logic [SEQ_W-1:0] head_sequence_out;
    logic [TOT_W-1:0] total_in_order;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture input item
    logic execute;  // apply the classified operation
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy_unused;
  } dp_stat_t;

endpackage

// ===== rtl/tcp_reassembly_range_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tcp_reassembly_range_tracker_unit
// Tracks received TCP byte ranges ahead of the head sequence.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake
// in_      | input     | in_valid / in_stall, payload in_data
// out_     | output    | out_valid / out_stall, payload out_data
// cfg_     | input     | cfg_we, cfg_index, cfg_data
//
// Each transaction is captured, then applied as one table update over all
// entries in parallel lanes. A result is held in the output register until
// taken; the next transaction is accepted in the cycle the result leaves.
// Reset clears control state and count; no clearing pass is needed.
module tcp_reassembly_range_tracker_unit #(
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  trt_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output trt_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [trt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trt_pkg::SEQ_W-1:0]     cfg_data
);
  import trt_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  trt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .dp_cmd(dp_cmd), .dp_stat(dp_stat)
  );

  trt_datapath #(.MAX_RANGES(MAX_RANGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_data(in_data), .out_data(out_data),
    .dp_cmd(dp_cmd), .dp_stat(dp_stat)
  );

endmodule

// ===== rtl/trt_ctrl.sv =====
// ----------------------------------------------------------------------------
// trt_ctrl
// Controller: load, execute, then present the result transaction.
// ----------------------------------------------------------------------------
module trt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output trt_pkg::dp_cmd_t dp_cmd,
  input  trt_pkg::dp_stat_t dp_stat
);
  import trt_pkg::*;
  `include "tcp_reassembly_range_tracker_unit_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc, out_acc;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (state_r != S_IDLE) && !(state_r == S_OUT && out_acc);
  assign out_valid = (state_r == S_OUT);

  assign dp_cmd.load    = in_acc;
  assign dp_cmd.execute = (state_r == S_EXEC) && !dp_stat.busy_unused;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc) state_nxt = in_acc ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `TRT_ASSERT_NEXT(a_load_execs, clk, rst_n, in_acc, state_r == S_EXEC, "load not followed by execute")
  `TRT_ASSERT_NEXT(a_exec_out, clk, rst_n, state_r == S_EXEC, out_valid, "execute not followed by result")
  `TRT_ASSERT_IMPL(a_one_hot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")

endmodule

// ===== rtl/trt_datapath.sv =====
// ----------------------------------------------------------------------------
// trt_datapath
// Range table, head tracking and result register.
// ----------------------------------------------------------------------------
module trt_datapath #(
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [trt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trt_pkg::SEQ_W-1:0] cfg_data,
  input  trt_pkg::in_item_t        in_data,
  output trt_pkg::out_item_t       out_data,
  input  trt_pkg::dp_cmd_t         dp_cmd,
  output trt_pkg::dp_stat_t        dp_stat
);
  import trt_pkg::*;
  `include "tcp_reassembly_range_tracker_unit_assert.svh"

  localparam int unsigned IW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned RW = SEQ_W + 1;

  logic [LEN_W-1:0] buf_size_r;
  logic [SEQ_W-1:0] init_seq_r;
  logic [SEQ_W-1:0] rstart_r [MAX_RANGES];
  logic [LEN_W-1:0] rlen_r   [MAX_RANGES];
  logic [CW-1:0]    count_r;
  logic [SEQ_W-1:0] head_r;
  logic [LEN_W-1:0] merged_r;
  logic [TOT_W-1:0] total_r;
  in_item_t         item_r;
  out_item_t        res_r;

  assign out_data = res_r;
  assign dp_stat.busy_unused = 1'b0;

  // Per-entry compare against the captured segment, in parallel lanes.
  logic [SEQ_W-1:0] ns;
  logic [RW-1:0]    ne;
  logic [MAX_RANGES-1:0] hit, lower;
  logic [RW-1:0]    es [MAX_RANGES];
  logic [SEQ_W-1:0] ss [MAX_RANGES];

  assign ns = item_r.segment_sequence - head_r;
  assign ne = {1'b0, ns} + RW'(item_r.byte_count);

  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      ss[i]     = rstart_r[i] - head_r;
      es[i]     = {1'b0, ss[i]} + RW'(rlen_r[i]);
      hit[i]    = (CW'(i) < count_r) && ({1'b0, ns} <= es[i]) && ({1'b0, ss[i]} <= ne);
      lower[i]  = (CW'(i) < count_r) && (ss[i] < ns);
    end
  end

  logic any;
  logic [IW-1:0] first, last, pos;
  logic [CW-1:0] gone;
  always_comb begin
    first = '0;
    last  = '0;
    pos   = '0;
    for (int i = MAX_RANGES - 1; i >= 0; i--) if (hit[i]) first = IW'(i);
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (hit[i]) last = IW'(i);
      if (lower[i]) pos = IW'(i + 1);
    end
    any  = |hit;
    gone = CW'(last) - CW'(first);
  end

  logic stale, no_room, is_full;
  logic [SEQ_W-1:0] diff_hs;
  assign diff_hs = item_r.segment_sequence - head_r;
  assign stale   = diff_hs > SEQ_HALF;
  assign no_room = ne > RW'(buf_size_r);
  assign is_full = !any && (count_r >= CW'(MAX_RANGES));

  logic [SEQ_W-1:0] mss;
  logic [RW-1:0]    mse;
  assign mss = (ss[first] < ns) ? ss[first] : ns;
  assign mse = (es[last] > ne) ? es[last] : ne;

  // Remove amount.
  logic [LEN_W-1:0] rm_n;
  assign rm_n = (item_r.byte_count > merged_r) ? merged_r : item_r.byte_count;

  logic [SEQ_W-1:0] nstart [MAX_RANGES];
  logic [LEN_W-1:0] nlen   [MAX_RANGES];
  logic [CW-1:0]    count_nxt;
  logic [SEQ_W-1:0] head_nxt;
  logic [LEN_W-1:0] merged_nxt;
  logic [TOT_W-1:0] total_nxt;
  logic [1:0]       st;
  logic [LEN_W-1:0] done;
  logic             put_ok;

  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      nstart[i] = rstart_r[i];
      nlen[i]   = rlen_r[i];
    end
    count_nxt  = count_r;
    head_nxt   = head_r;
    merged_nxt = merged_r;
    total_nxt  = total_r;
    st         = ST_IGNORED;
    done       = '0;
    put_ok     = 1'b0;
    unique case (cmd_t'(item_r.command))
      CMD_PUT: begin
        if (item_r.byte_count == '0 || stale) st = ST_IGNORED;
        else if (no_room) st = ST_NO_ROOM;
        else if (is_full) st = ST_FULL;
        else begin
          st     = ST_DONE;
          done   = item_r.byte_count;
          put_ok = 1'b1;
          if (any) begin
            for (int i = 0; i < MAX_RANGES; i++) begin
              if (IW'(i) == first) begin
                nstart[i] = head_r + mss;
                nlen[i]   = LEN_W'(mse - {1'b0, mss});
              end else if (IW'(i) > first && (i + 32'(gone)) < MAX_RANGES) begin
                nstart[i] = rstart_r[i + 32'(gone)];
                nlen[i]   = rlen_r[i + 32'(gone)];
              end
            end
            count_nxt = count_r - gone;
          end else begin
            for (int i = 0; i < MAX_RANGES; i++) begin
              if (IW'(i) == pos) begin
                nstart[i] = item_r.segment_sequence;
                nlen[i]   = item_r.byte_count;
              end else if (IW'(i) > pos && i > 0) begin
                nstart[i] = rstart_r[i-1];
                nlen[i]   = rlen_r[i-1];
              end
            end
            count_nxt = count_r + 1'b1;
          end
          if (count_nxt != '0 && nstart[0] == head_r) begin
            total_nxt  = total_r + TOT_W'(nlen[0]) - TOT_W'(merged_r);
            merged_nxt = nlen[0];
          end
        end
      end
      CMD_REMOVE: begin
        if (rm_n != '0 && count_r != '0) begin
          st         = ST_DONE;
          done       = rm_n;
          head_nxt   = head_r + SEQ_W'(rm_n);
          merged_nxt = merged_r - rm_n;
          if (rm_n >= rlen_r[0]) begin
            for (int i = 0; i + 1 < MAX_RANGES; i++) begin
              nstart[i] = rstart_r[i+1];
              nlen[i]   = rlen_r[i+1];
            end
            count_nxt = count_r - 1'b1;
          end else begin
            nstart[0] = rstart_r[0] + SEQ_W'(rm_n);
            nlen[0]   = rlen_r[0] - rm_n;
          end
        end
      end
      CMD_RESTART: begin
        st         = ST_DONE;
        count_nxt  = '0;
        head_nxt   = init_seq_r;
        merged_nxt = '0;
        total_nxt  = '0;
      end
      default: st = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) item_r <= in_data;
    if (dp_cmd.execute) begin
      for (int i = 0; i < MAX_RANGES; i++) begin
        rstart_r[i] <= nstart[i];
        rlen_r[i]   <= nlen[i];
      end
      res_r.status            <= st;
      res_r.bytes_done        <= done;
      res_r.contiguous_length <= merged_nxt;
      res_r.head_sequence_out <= head_nxt;
      res_r.total_in_order    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= LEN_W'(8192);
      init_seq_r <= '0;
      count_r    <= '0;
      head_r     <= '0;
      merged_r   <= '0;
      total_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_BUFFER_SIZE:      buf_size_r <= cfg_data[LEN_W-1:0];
          REG_INITIAL_SEQUENCE: init_seq_r <= cfg_data;
          default: ;
        endcase
      end
      if (dp_cmd.execute) begin
        count_r  <= count_nxt;
        head_r   <= head_nxt;
        merged_r <= merged_nxt;
        total_r  <= total_nxt;
      end
    end
  end

  `TRT_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(MAX_RANGES),
                   "range count overflow")
  `TRT_ASSERT_NEXT(a_put_grows, clk, rst_n, dp_cmd.execute && put_ok && !any,
                   count_r == $past(count_r) + 1'b1, "insert did not grow table")
  `TRT_ASSERT_IMPL(a_merged_le_first, clk, rst_n, merged_r != '0, count_r != '0,
                   "merged length without ranges")

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TCP reassembly range tracker: a behavioral
// range table predicts every result; random idle on the input, stall on the output.
// ----------------------------------------------------------------------------
module testbench;
  import trt_pkg::*;

  localparam int unsigned MAX_RANGES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Behavioral range table and ordered store of predicted results.
  class range_scoreboard;
    logic [20:0] win_size;
    logic [31:0] restart_seq;
    logic [31:0] seg_start [MAX_RANGES];
    logic [20:0] seg_len [MAX_RANGES];
    int unsigned seg_count;
    logic [31:0] head;
    logic [20:0] in_order_len;
    logic [63:0] total_len;
    out_item_t pending_results [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      win_size = 21'd8192;
      restart_seq = '0;
      seg_count = 0;
      head = '0;
      in_order_len = '0;
      total_len = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      if (idx == REG_BUFFER_SIZE) win_size = value[20:0];
      else restart_seq = value;
    endfunction

    function bit head_not_after(logic [31:0] seq);
      logic [31:0] d;
      d = seq - head;
      return d <= SEQ_HALF;
    endfunction

    function logic [63:0] offset_of(logic [31:0] seq);
      logic [31:0] d;
      d = seq - head;
      return {32'd0, d};
    endfunction

    function status_t apply_put(logic [31:0] seq, logic [20:0] len);
      logic [63:0] ns, ne, s, e;
      int unsigned first, last, gone, pos;
      bit any;
      first = 0; last = 0; any = 0;
      if (len == 0 || !head_not_after(seq)) return ST_IGNORED;
      ns = offset_of(seq);
      ne = ns + len;
      if (ne > {43'd0, win_size}) return ST_NO_ROOM;
      for (int i = 0; i < seg_count; i++) begin
        s = offset_of(seg_start[i]);
        e = s + seg_len[i];
        if (ns <= e && s <= ne) begin
          if (!any) first = i;
          last = i;
          any = 1;
        end
      end
      if (any) begin
        s = offset_of(seg_start[first]);
        e = offset_of(seg_start[last]) + seg_len[last];
        gone = last - first;
        if (s < ns) ns = s;
        if (e > ne) ne = e;
        seg_start[first] = head + ns[31:0];
        seg_len[first] = ne[20:0] - ns[20:0];
        for (int i = first + 1; i + gone < seg_count; i++) begin
          seg_start[i] = seg_start[i + gone];
          seg_len[i] = seg_len[i + gone];
        end
        seg_count -= gone;
      end else begin
        if (seg_count >= MAX_RANGES) return ST_FULL;
        pos = 0;
        while (pos < seg_count && offset_of(seg_start[pos]) < ns) pos++;
        for (int i = seg_count; i > pos; i--) begin
          seg_start[i] = seg_start[i - 1];
          seg_len[i] = seg_len[i - 1];
        end
        seg_start[pos] = seq;
        seg_len[pos] = len;
        seg_count++;
      end
      if (seg_count > 0 && seg_start[0] == head) begin
        total_len = total_len + seg_len[0] - in_order_len;
        in_order_len = seg_len[0];
      end
      return ST_DONE;
    endfunction

    function status_t apply_remove(logic [20:0] req, output logic [20:0] taken);
      logic [20:0] n;
      taken = '0;
      n = (req > in_order_len) ? in_order_len : req;
      if (n == 0 || seg_count == 0) return ST_IGNORED;
      head += n;
      in_order_len -= n;
      if (n >= seg_len[0]) begin
        for (int i = 1; i < seg_count; i++) begin
          seg_start[i - 1] = seg_start[i];
          seg_len[i - 1] = seg_len[i];
        end
        seg_count--;
      end else begin
        seg_start[0] += n;
        seg_len[0] -= n;
      end
      taken = n;
      return ST_DONE;
    endfunction

    function void note_input(in_item_t item);
      out_item_t r;
      status_t st;
      logic [20:0] taken;
      st = ST_IGNORED;
      taken = '0;
      case (cmd_t'(item.command))
        CMD_PUT: begin
          st = apply_put(item.segment_sequence, item.byte_count);
          if (st == ST_DONE) taken = item.byte_count;
        end
        CMD_REMOVE: st = apply_remove(item.byte_count, taken);
        CMD_RESTART: begin
          seg_count = 0;
          head = restart_seq;
          in_order_len = '0;
          total_len = '0;
          st = ST_DONE;
        end
        default: st = ST_IGNORED;
      endcase
      r.status = st;
      r.bytes_done = taken;
      r.contiguous_length = in_order_len;
      r.head_sequence_out = head;
      r.total_in_order = total_len;
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH result %0d %s: got %0h want %0h", checked, what, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'(got.head_sequence_out), 64'd0);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
      if (got.bytes_done !== want.bytes_done)
        report("bytes_done", 64'(got.bytes_done), 64'(want.bytes_done));
      if (got.contiguous_length !== want.contiguous_length)
        report("contiguous_length", 64'(got.contiguous_length),
               64'(want.contiguous_length));
      if (got.head_sequence_out !== want.head_sequence_out)
        report("head_sequence_out", 64'(got.head_sequence_out),
               64'(want.head_sequence_out));
      if (got.total_in_order !== want.total_in_order)
        report("total_in_order", got.total_in_order, want.total_in_order);
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SEQ_W-1:0] cfg_data;

  range_scoreboard tracker_model;
  int unsigned cycle_count;
  int unsigned items_sent;
  bit stall_enable;

  tcp_reassembly_range_tracker_unit #(.MAX_RANGES(MAX_RANGES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Check results and drive out_stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker_model.check_result(out_data);
    if (!stall_enable) out_stall <= 1'b0;
    else out_stall <= (gap_len() != 0);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Valid stays high into the next transaction when there is no gap.
  task automatic send_item(cmd_t cmd, logic [31:0] seq, logic [20:0] cnt);
    in_item_t item;
    int unsigned g;
    item.command = cmd;
    item.segment_sequence = seq;
    item.byte_count = cnt;
    g = stall_enable ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    tracker_model.note_input(item);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker_model.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker_model.write_reg(idx, value);
  endtask

  // Mostly well-formed traffic: segments near head, some stale or overrun.
  task automatic random_phase(int unsigned n);
    logic [31:0] off;
    logic [20:0] len;
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        off = $urandom_range(0, 2000);
        len = 21'($urandom_range(1, 300));
        send_item(CMD_PUT, tracker_model.head + off, len);
      end else if (r < 80) begin
        send_item(CMD_REMOVE, $urandom, 21'($urandom_range(0, 600)));
      end else if (r < 83) begin
        send_item(CMD_RESTART, $urandom, 21'($urandom));
      end else if (r < 85) begin
        send_item(CMD_NONE, $urandom, 21'($urandom));
      end else begin
        send_item(CMD_PUT, $urandom, 21'($urandom));
      end
    end
  endtask

  initial begin
    tracker_model = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    items_sent = 0;
    stall_enable = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty, stale, overrun, merge, full table, removes, restart.
    send_item(CMD_PUT, 32'd0, 21'd0);
    send_item(CMD_PUT, 32'hFFFF_FFF0, 21'd10);
    send_item(CMD_PUT, 32'h8000_0000, 21'd1);
    send_item(CMD_PUT, 32'd100, 21'h1F_FFFF);
    send_item(CMD_PUT, 32'd8191, 21'd1);
    send_item(CMD_PUT, 32'd8191, 21'd2);
    send_item(CMD_REMOVE, 32'd0, 21'd5);
    for (int i = 0; i < 17; i++) send_item(CMD_PUT, 32'd20 * i + 10, 21'd5);
    send_item(CMD_PUT, 32'd0, 21'd200);
    send_item(CMD_REMOVE, 32'd0, 21'h1F_FFFF);
    send_item(CMD_REMOVE, 32'd0, 21'd0);
    send_item(CMD_NONE, 32'hFFFF_FFFF, 21'h1F_FFFF);
    write_cfg(REG_INITIAL_SEQUENCE, 32'hFFFF_FF00);
    write_cfg(REG_BUFFER_SIZE, 32'd1048576);
    send_item(CMD_RESTART, 32'd0, 21'd0);
    send_item(CMD_PUT, 32'hFFFF_FF00, 21'd1048576);
    send_item(CMD_REMOVE, 32'd0, 21'd1000);

    stall_enable = 1;
    random_phase(180);
    write_cfg(REG_BUFFER_SIZE, 32'd1);
    write_cfg(REG_INITIAL_SEQUENCE, 32'hFFFF_FFFF);
    send_item(CMD_RESTART, 32'd0, 21'd0);
    random_phase(60);
    write_cfg(REG_BUFFER_SIZE, 32'd4000);
    write_cfg(REG_INITIAL_SEQUENCE, $urandom);
    send_item(CMD_RESTART, 32'd0, 21'd0);
    stall_enable = 0;
    random_phase(60);
    stall_enable = 1;
    random_phase(220);

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d transactions, %0d results checked, six register writes.",
             items_sent, tracker_model.checked);
    if (tracker_model.errors == 0 && tracker_model.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
